// ===== rtl/mpcs_pkg.sv =====
// shared types, codes and field widths for the motor pwm command shaper
`default_nettype none

package mpcs_pkg;

    // field widths
    localparam int ChannelWidth = 2;
    localparam int CommandWidth = 16;
    localparam int DutyWidth    = 15;
    localparam int ModeWidth    = 2;
    localparam int CfgIndexWidth = 2;

    // packed stream widths, rounded up to whole bytes
    localparam int InFieldBits  = 2 * ChannelWidth / 2 + 2 * CommandWidth + DutyWidth + 3;
    localparam int InDataWidth  = ((InFieldBits + 7) / 8) * 8;
    localparam int OutFieldBits = ChannelWidth + DutyWidth + 1 + CommandWidth;
    localparam int OutDataWidth = ((OutFieldBits + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_DUTY_FLOOR    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_DUTY_CEILING  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_POLARITY_MODE = 2'd2;

    // polarity modes; the unused code acts as always invert
    localparam logic [ModeWidth-1:0] POL_NEVER    = 2'd0;
    localparam logic [ModeWidth-1:0] POL_NEGATIVE = 2'd1;
    localparam logic [ModeWidth-1:0] POL_ALWAYS   = 2'd2;

    // reset values of the configuration registers
    localparam logic [DutyWidth-1:0] DUTY_FLOOR_RESET   = 15'd0;
    localparam logic [DutyWidth-1:0] DUTY_CEILING_RESET = 15'd32767;
    localparam logic [ModeWidth-1:0] POLARITY_RESET     = POL_NEGATIVE;

    typedef struct packed {
        logic [DutyWidth-1:0] duty_floor;
        logic [DutyWidth-1:0] duty_ceiling;
        logic [ModeWidth-1:0] polarity_mode;
    } cfg_t;

    typedef struct packed {
        logic                           at_upper_stop;
        logic                           at_lower_stop;
        logic                           forward_positive;
        logic        [DutyWidth-1:0]    limit_max;
        logic signed [CommandWidth-1:0] deadband;
        logic signed [CommandWidth-1:0] command;
        logic        [ChannelWidth-1:0] channel;
    } in_item_t;

    typedef struct packed {
        logic signed [CommandWidth-1:0] echoed_command;
        logic                           direction;
        logic        [DutyWidth-1:0]    duty;
        logic        [ChannelWidth-1:0] channel_out;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/mpcs_core.sv =====
// combinational shaping path: end stops, deadband, limit and polarity clamp
`default_nettype none

module mpcs_core
    import mpcs_pkg::*;
(
    input  wire cfg_t      cfg,
    input  wire in_item_t  item,
    output out_item_t      result
);

    logic                   cmd_neg;
    logic                   cmd_pos;
    logic                   stop_hit;
    logic [16:0]            abs_cmd;
    logic [16:0]            mag_stop;
    logic [16:0]            db_size;
    logic [16:0]            mag;
    logic [DutyWidth-1:0]   lim_ce;
    logic [DutyWidth-1:0]   pm;
    logic                   invert;
    logic signed [17:0]     ce_s;
    logic signed [17:0]     fl_s;
    logic signed [17:0]     pm_s;
    logic signed [17:0]     mag_s;
    logic signed [17:0]     x_s;
    logic signed [17:0]     lo_s;
    logic signed [17:0]     hi_s;
    logic signed [17:0]     clamp_s;
    logic signed [17:0]     duty_s;
    logic [DutyWidth-1:0]   echo_mag;
    logic [CommandWidth-1:0] echo_pos;

    // command sign and end stop protection
    assign cmd_neg = item.command[CommandWidth-1];
    assign cmd_pos = !cmd_neg && (item.command != '0);
    assign stop_hit =
        (item.at_lower_stop && ((cmd_neg && item.forward_positive) ||
                                (cmd_pos && !item.forward_positive))) ||
        (item.at_upper_stop && ((cmd_pos && item.forward_positive) ||
                                (cmd_neg && !item.forward_positive)));

    // magnitude after the end stop check
    assign abs_cmd  = cmd_neg ? ({1'b0, ~item.command} + 17'd1) : {1'b0, item.command};
    assign mag_stop = stop_hit ? 17'd0 : abs_cmd;

    // deadband: zero zone when negative, offset when positive
    assign db_size = {1'b0, ~item.deadband} + 17'd1;
    always_comb
    begin
        if (mag_stop == 17'd0)
        begin
            mag = 17'd0;
        end
        else if (item.deadband[CommandWidth-1])
        begin
            mag = (mag_stop < db_size) ? 17'd0 : mag_stop;
        end
        else
        begin
            mag = mag_stop + {1'b0, item.deadband};
        end
    end

    // effective limit inside the global duty range
    assign lim_ce = (item.limit_max < cfg.duty_ceiling) ? item.limit_max : cfg.duty_ceiling;
    assign pm     = (lim_ce < cfg.duty_floor) ? cfg.duty_floor : lim_ce;

    // polarity selection
    always_comb
    begin
        unique case (cfg.polarity_mode)
            POL_NEVER:    invert = 1'b0;
            POL_NEGATIVE: invert = cmd_neg;
            default:      invert = 1'b1;
        endcase
    end

    // duty clamp, direct or inverted against the ceiling
    assign ce_s  = $signed({3'b000, cfg.duty_ceiling});
    assign fl_s  = $signed({3'b000, cfg.duty_floor});
    assign pm_s  = $signed({3'b000, pm});
    assign mag_s = $signed({1'b0, mag});
    assign x_s   = invert ? (ce_s - mag_s) : mag_s;
    assign lo_s  = invert ? (ce_s - pm_s)  : fl_s;
    assign hi_s  = invert ? (ce_s - fl_s)  : pm_s;

    always_comb
    begin
        priority if (x_s < lo_s)
        begin
            clamp_s = lo_s;
        end
        else if (x_s > hi_s)
        begin
            clamp_s = hi_s;
        end
        else
        begin
            clamp_s = x_s;
        end
    end

    // saturate into the timer's duty range
    always_comb
    begin
        priority if (clamp_s < 18'sd0)
        begin
            duty_s = 18'sd0;
        end
        else if (clamp_s > 18'sd32767)
        begin
            duty_s = 18'sd32767;
        end
        else
        begin
            duty_s = clamp_s;
        end
    end

    // echoed command: sign times magnitude clamped to the channel limit
    assign echo_mag = (mag < {2'b00, item.limit_max}) ? mag[DutyWidth-1:0] : item.limit_max;
    assign echo_pos = {1'b0, echo_mag};

    assign result.channel_out    = item.channel;
    assign result.duty           = duty_s[DutyWidth-1:0];
    assign result.direction      = !cmd_pos;
    assign result.echoed_command = cmd_neg ? $signed(-echo_pos) : $signed(echo_pos);

endmodule

`default_nettype wire

// ===== rtl/motor_pwm_command_shaper.sv =====
// top level of the motor pwm command shaper: config registers and two-stage word pipeline
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: command word with deadband, limit and stop flags
// m_*       out  m_tvalid/m_tready  m_tdata: duty, direction and echoed command
// cfg_*     in   cfg_we             cfg_index, cfg_data: global duty range and polarity mode
//
// one word per cycle while results are taken; an accepted word goes through the
// input register then the result register, with the shaping logic between them.
// rst_n clears both valid flags and loads floor 0, ceiling 32767, polarity mode 1.
// a stall on m_tready holds the result; the input register still takes one more word,
// and s_tready drops only when both stages are full and the result is not taken.
`default_nettype none

module motor_pwm_command_shaper
    import mpcs_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    // configuration write port
    input  wire                      cfg_we,
    input  wire [CfgIndexWidth-1:0]  cfg_index,
    input  wire [DutyWidth-1:0]      cfg_data,
    // input words
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // channel[1:0], command[17:2], deadband[33:18], limit_max[48:34],
    // forward_positive[49], at_lower_stop[50], at_upper_stop[51], zero fill above
    input  wire [InDataWidth-1:0]    s_tdata,
    // result words
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // channel_out[1:0], duty[16:2], direction[17], echoed_command[33:18], zero fill above
    output logic [OutDataWidth-1:0]  m_tdata
);

    cfg_t      cfg_reg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t shaped;
    logic      advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_floor    <= DUTY_FLOOR_RESET;
            cfg_reg.duty_ceiling  <= DUTY_CEILING_RESET;
            cfg_reg.polarity_mode <= POLARITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DUTY_FLOOR:    cfg_reg.duty_floor    <= cfg_data;
                CFG_DUTY_CEILING:  cfg_reg.duty_ceiling  <= cfg_data;
                CFG_POLARITY_MODE: cfg_reg.polarity_mode <= cfg_data[ModeWidth-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_t'(s_tdata[InFieldBits-1:0]);
        end
    end

    // shaping logic
    mpcs_core u_core (
        .cfg    (cfg_reg),
        .item   (in_item_reg),
        .result (shaped)
    );

    // result register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= shaped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataWidth - OutFieldBits){1'b0}}, out_item_reg};

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the motor pwm command shaper: directed and random command words against a local duty model
`timescale 1ns / 1ps

module tb;
    import mpcs_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int MaxDuty    = (1 << DutyWidth) - 1;
    // the spare polarity code behaves as always invert
    localparam logic [ModeWidth-1:0] POL_SPARE = 2'd3;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [DutyWidth-1:0]    cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;

    // shadow of the configuration registers
    logic [DutyWidth-1:0] floor_q = DUTY_FLOOR_RESET;
    logic [DutyWidth-1:0] ceil_q  = DUTY_CEILING_RESET;
    logic [ModeWidth-1:0] mode_q  = POLARITY_RESET;

    out_item_t pending_duty_q[$];
    int        mismatches = 0;
    int        cycles     = 0;
    bit        tx_idle    = 1'b1;
    bit        rx_idle    = 1'b1;
    int        rx_hold    = 0;

    motor_pwm_command_shaper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int clip(int x, int lo, int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // expected result word for one command word under the shadow config
    function automatic out_item_t shape_command(in_item_t w);
        out_item_t r;
        int cmd, db, lim, sgn, val, mag, fl, ce, pm, d, echo;
        bit inv;
        cmd = int'(w.command);
        db  = int'(w.deadband);
        lim = int'(w.limit_max);
        sgn = (cmd > 0) ? 1 : ((cmd < 0) ? -1 : 0);
        val = cmd;
        // driving into an active end stop gives zero
        if (w.at_lower_stop && ((val < 0 && w.forward_positive) ||
                                (val > 0 && !w.forward_positive)))
            val = 0;
        if (w.at_upper_stop && ((val > 0 && w.forward_positive) ||
                                (val < 0 && !w.forward_positive)))
            val = 0;
        // deadband: zero zone when negative, offset otherwise
        mag = (val < 0) ? -val : val;
        if (mag != 0)
        begin
            if (db < 0)
            begin
                if (mag < -db) mag = 0;
            end
            else
                mag += db;
        end
        // channel limit inside the global duty range
        fl = int'(floor_q);
        ce = int'(ceil_q);
        pm = (lim < ce) ? lim : ce;
        if (pm < fl) pm = fl;
        case (mode_q)
            POL_NEVER:    inv = 1'b0;
            POL_NEGATIVE: inv = (sgn < 0);
            default:      inv = 1'b1;
        endcase
        d = inv ? clip(ce - mag, ce - pm, ce - fl) : clip(mag, fl, pm);
        d = clip(d, 0, MaxDuty);
        echo = sgn * clip(mag, 0, lim);
        r.channel_out    = w.channel;
        r.duty           = d[DutyWidth-1:0];
        r.direction      = (sgn <= 0);
        r.echoed_command = echo[CommandWidth-1:0];
        return r;
    endfunction

    function automatic in_item_t make_word(int chan, int cmd, int db, int lim,
                                           bit fwd, bit lower, bit upper);
        in_item_t w;
        w.channel          = chan[ChannelWidth-1:0];
        w.command          = cmd[CommandWidth-1:0];
        w.deadband         = db[CommandWidth-1:0];
        w.limit_max        = lim[DutyWidth-1:0];
        w.forward_positive = fwd;
        w.at_lower_stop    = lower;
        w.at_upper_stop    = upper;
        return w;
    endfunction

    // signed 16-bit value leaning toward extremes and small magnitudes
    function automatic int pick_signed();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 300);
            3:       return -int'($urandom_range(0, 300));
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic in_item_t random_word();
        int lim;
        case ($urandom_range(0, 4))
            0:       lim = 0;
            1:       lim = MaxDuty;
            2:       lim = $urandom_range(0, 2000);
            default: lim = $urandom_range(0, MaxDuty);
        endcase
        return make_word($urandom_range(0, 3), pick_signed(), pick_signed(), lim,
                         1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                         ($urandom_range(0, 3) == 0));
    endfunction

    // offer one word, called at a clock edge; returns at the edge that takes it
    task automatic send_word(input in_item_t w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= InDataWidth'(w);
        do @(posedge clk); while (!s_tready);
        pending_duty_q.push_back(shape_command(w));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_duty_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [DutyWidth-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DUTY_FLOOR:   floor_q = val;
            CFG_DUTY_CEILING: ceil_q  = val;
            default:          mode_q  = val[ModeWidth-1:0];
        endcase
    endtask

    task automatic set_config(input int fl, input int ce, input logic [ModeWidth-1:0] mode);
        wait_idle();
        write_reg(CFG_DUTY_FLOOR, fl[DutyWidth-1:0]);
        write_reg(CFG_DUTY_CEILING, ce[DutyWidth-1:0]);
        write_reg(CFG_POLARITY_MODE, DutyWidth'(mode));
        cfg_we <= 1'b0;
    endtask

    // extremes, stop cases and deadband cases under the reset config
    task automatic test_directed_words();
        send_word(make_word(0, 0, 0, MaxDuty, 1, 0, 0));
        send_word(make_word(1, 32767, 0, MaxDuty, 1, 0, 0));
        send_word(make_word(2, -32768, 0, MaxDuty, 1, 0, 0));
        send_word(make_word(3, 1000, 0, 500, 1, 0, 0));
        send_word(make_word(0, 100, -200, MaxDuty, 1, 0, 0));
        send_word(make_word(1, -300, -200, MaxDuty, 0, 0, 0));
        send_word(make_word(2, 32767, 32767, MaxDuty, 1, 0, 0));
        send_word(make_word(0, -32768, -32768, 0, 0, 0, 0));
        send_word(make_word(0, -500, 0, MaxDuty, 1, 1, 0));
        send_word(make_word(1, 500, 0, MaxDuty, 0, 1, 0));
        send_word(make_word(2, 500, 0, MaxDuty, 1, 0, 1));
        send_word(make_word(0, -500, 0, MaxDuty, 0, 0, 1));
        send_word(make_word(1, -1, 5, 100, 1, 1, 1));
        send_word(make_word(2, 700, 0, MaxDuty, 1, 1, 0));
    endtask

    // floor above ceiling, spare mode, collapsed and narrow duty ranges
    task automatic test_config_corners();
        set_config(1000, 200, POL_NEGATIVE);
        send_word(make_word(0, 50, 0, 300, 1, 0, 0));
        send_word(make_word(1, -50, 0, 300, 1, 0, 0));
        send_word(make_word(2, 0, 10, 300, 1, 0, 0));
        set_config(0, 0, POL_SPARE);
        send_word(make_word(0, 1234, 0, MaxDuty, 1, 0, 0));
        send_word(make_word(3, 0, 0, MaxDuty, 0, 0, 0));
        set_config(MaxDuty, MaxDuty, POL_NEVER);
        send_word(make_word(1, -32768, 32767, MaxDuty, 0, 0, 0));
        send_word(make_word(2, 5, 0, 0, 1, 0, 0));
        set_config(100, 30000, POL_ALWAYS);
        send_word(make_word(0, 0, 0, 20000, 1, 0, 0));
        send_word(make_word(1, 32767, -100, 20000, 1, 0, 0));
    endtask

    task automatic random_phase(input int count);
        int fl, ce;
        case ($urandom_range(0, 4))
            0:       fl = 0;
            1:       fl = MaxDuty;
            2:       fl = $urandom_range(0, 2000);
            default: fl = $urandom_range(0, MaxDuty);
        endcase
        case ($urandom_range(0, 4))
            0:       ce = MaxDuty;
            1:       ce = 0;
            2:       ce = $urandom_range(20000, MaxDuty);
            default: ce = $urandom_range(0, MaxDuty);
        endcase
        set_config(fl, ce, ModeWidth'($urandom_range(0, 3)));
        repeat (count) send_word(random_word());
    endtask

    task automatic test_random_settings();
        repeat (12) random_phase(110);
    endtask

    // back to back on both sides
    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_phase(150);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // long receiver hold while the sender keeps offering words
    task automatic test_backpressure();
        set_config(0, MaxDuty, POL_NEGATIVE);
        tx_idle = 1'b0;
        rx_hold = 300;
        repeat (100) send_word(random_word());
        tx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_words();
        test_config_corners();
        test_random_settings();
        test_full_rate();
        test_backpressure();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: random stall before each result word, plus the long hold on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[OutFieldBits-1:0];
            if (pending_duty_q.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_duty_q.pop_front();
                compare_field("channel_out", int'(want.channel_out), int'(got.channel_out));
                compare_field("duty", int'(want.duty), int'(got.duty));
                compare_field("direction", int'(want.direction), int'(got.direction));
                compare_field("echoed_command", int'(want.echoed_command),
                              int'(got.echoed_command));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
